// ===== hw/rtl/bcg_pkg.sv =====
package bcg_pkg;

   localparam int TimeW  = 16;
   localparam int CountW = 4;
   localparam int DtW    = 10;
   localparam int GestW  = 4;
   localparam int IndexW = 3;

   localparam logic [TimeW-1:0]  TimeMax  = '1;
   localparam logic [CountW-1:0] CountMax = '1;
   localparam logic [CountW-1:0] MaxMulti = 4'd3;

   localparam logic [GestW-1:0] G_CLICK1 = 4'd0;
   localparam logic [GestW-1:0] G_HOLD1  = 4'd3;
   localparam logic [GestW-1:0] G_RESET  = 4'd9;
   localparam logic [GestW-1:0] G_OTA    = 4'd10;
   localparam logic [GestW-1:0] G_STUCK  = 4'd11;
   localparam logic [GestW-1:0] G_TICK   = 4'd12;

   localparam logic [IndexW-1:0] CSR_HOLD_THRESHOLD = 3'd0;
   localparam logic [IndexW-1:0] CSR_CLICK_WINDOW   = 3'd1;
   localparam logic [IndexW-1:0] CSR_RESET_CLICKS   = 3'd2;
   localparam logic [IndexW-1:0] CSR_OTA_CLICKS     = 3'd3;
   localparam logic [IndexW-1:0] CSR_OTA_HOLD       = 3'd4;
   localparam logic [IndexW-1:0] CSR_STUCK          = 3'd5;

   // results of one tick; a second result is always the reset gesture
   typedef struct packed {
      logic              two;
      logic [GestW-1:0]  gesture;
      logic [TimeW-1:0]  duration;
   } bundle_type;

   function automatic logic [TimeW-1:0] sat_add(logic [TimeW-1:0] a, logic [DtW-1:0] b);
      logic [TimeW:0] s;
      s = {1'b0, a} + {{(TimeW+1-DtW){1'b0}}, b};
      return s[TimeW] ? TimeMax : s[TimeW-1:0];
   endfunction

endpackage

// ===== hw/rtl/bcg_front.sv =====
module bcg_front import bcg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept_i,
   input  logic              pressed_i,
   input  logic [DtW-1:0]    elapsed_i,
   input  logic              csr_valid,
   input  logic [IndexW-1:0] csr_index,
   input  logic [TimeW-1:0]  csr_data,
   output logic              push_o,
   output bundle_type        bundle_o
);

   typedef enum logic [2:0] {
      IDLE, PRESS, HOLD, OTA_HOLD, GAP, SWALLOW
   } mode_type;

   mode_type          mode_ff, mode_in;
   logic              level_ff;
   logic [CountW-1:0] count_ff, count_in;
   logic [TimeW-1:0]  press_ff, press_in;
   logic [TimeW-1:0]  gap_ff, gap_in;

   logic [TimeW-1:0]  hold_thr_ff, window_ff, ota_hold_ff, stuck_ff;
   logic [CountW-1:0] reset_clicks_ff, ota_clicks_ff;

   logic              rise, fall;
   logic [TimeW-1:0]  press_sum, gap_sum;
   logic [CountW-1:0] count_inc;
   logic [GestW-1:0]  hold_code;

   assign rise      = pressed_i & ~level_ff;
   assign fall      = ~pressed_i & level_ff;
   assign press_sum = sat_add(press_ff, elapsed_i);
   assign gap_sum   = sat_add(gap_ff, elapsed_i);
   assign count_inc = (count_ff == CountMax) ? count_ff : count_ff + 4'd1;
   assign hold_code = G_HOLD1 + {1'b0, count_ff[1:0], 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_thr_ff     <= 16'd500;
         window_ff       <= 16'd400;
         reset_clicks_ff <= 4'd10;
         ota_clicks_ff   <= 4'd4;
         ota_hold_ff     <= 16'd10000;
         stuck_ff        <= 16'd30000;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_HOLD_THRESHOLD: hold_thr_ff     <= csr_data;
            CSR_CLICK_WINDOW:   window_ff       <= csr_data;
            CSR_RESET_CLICKS:   reset_clicks_ff <= csr_data[CountW-1:0];
            CSR_OTA_CLICKS:     ota_clicks_ff   <= csr_data[CountW-1:0];
            CSR_OTA_HOLD:       ota_hold_ff     <= csr_data;
            CSR_STUCK:          stuck_ff        <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      press_in = press_ff;
      gap_in   = gap_ff;
      push_o   = 1'b0;
      bundle_o = '0;
      case (mode_ff)
         PRESS: begin
            press_in = press_sum;
            if (fall) begin
               push_o           = 1'b1;
               bundle_o.gesture = G_TICK;
               if (count_inc >= reset_clicks_ff) begin
                  bundle_o.two = 1'b1;
                  mode_in      = IDLE;
                  count_in     = '0;
                  press_in     = '0;
                  gap_in       = '0;
               end else begin
                  mode_in  = GAP;
                  count_in = count_inc;
                  gap_in   = '0;
               end
            end else if (press_sum >= hold_thr_ff) begin
               if (count_ff < MaxMulti) begin
                  push_o           = 1'b1;
                  bundle_o.gesture = hold_code;
                  mode_in          = HOLD;
               end else if (count_ff == ota_clicks_ff) begin
                  mode_in = OTA_HOLD;
               end else begin
                  mode_in = SWALLOW;
               end
            end
         end
         HOLD: begin
            press_in = press_sum;
            if (fall || press_sum >= stuck_ff) begin
               bundle_o.duration = press_sum;
               if (fall) begin
                  push_o           = count_ff < MaxMulti;
                  bundle_o.gesture = hold_code + 4'd1;
               end else begin
                  push_o           = 1'b1;
                  bundle_o.gesture = G_STUCK;
               end
               mode_in  = IDLE;
               count_in = '0;
               press_in = '0;
               gap_in   = '0;
            end
         end
         OTA_HOLD: begin
            press_in = press_sum;
            if (fall) begin
               mode_in  = IDLE;
               count_in = '0;
               press_in = '0;
               gap_in   = '0;
            end else if (press_sum >= ota_hold_ff) begin
               push_o            = 1'b1;
               bundle_o.gesture  = G_OTA;
               bundle_o.duration = press_sum;
               mode_in           = SWALLOW;
            end
         end
         GAP: begin
            gap_in = gap_sum;
            if (rise) begin
               mode_in  = PRESS;
               press_in = '0;
            end else if (gap_sum >= window_ff) begin
               push_o           = (count_ff != '0) && (count_ff <= MaxMulti);
               bundle_o.gesture = G_CLICK1 + count_ff - 4'd1;
               mode_in          = IDLE;
               count_in         = '0;
               press_in         = '0;
               gap_in           = '0;
            end
         end
         SWALLOW: begin
            if (fall) begin
               mode_in  = IDLE;
               count_in = '0;
               press_in = '0;
               gap_in   = '0;
            end
         end
         default: begin
            mode_in = IDLE;
            if (rise) begin
               mode_in  = PRESS;
               press_in = '0;
            end
         end
      endcase
      if (!accept_i) begin
         push_o = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= IDLE;
         level_ff <= 1'b0;
         count_ff <= '0;
         press_ff <= '0;
         gap_ff   <= '0;
      end else if (accept_i) begin
         mode_ff  <= mode_in;
         level_ff <= pressed_i;
         count_ff <= count_in;
         press_ff <= press_in;
         gap_ff   <= gap_in;
      end
   end

endmodule

// ===== hw/rtl/bcg_queue.sv =====
module bcg_queue import bcg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push_i,
   input  bundle_type bundle_i,
   input  logic       pop_i,
   output logic       full_o,
   output logic       valid_o,
   output bundle_type head_o
);

   bundle_type store_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full_o  = count_ff == 2'd2;
   assign valid_o = count_ff != 2'd0;
   assign head_o  = store_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push_i) begin
         store_ff[wr_ptr_ff] <= bundle_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push_i) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop_i) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push_i} - {1'b0, pop_i};
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_i |-> count_ff != 2'd2) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop_i |-> count_ff != 2'd0) else $error("queue underflow");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push_i && !pop_i) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count lost a push");
`endif

endmodule

// ===== hw/rtl/bcg_back.sv =====
module bcg_back import bcg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             valid_i,
   input  bundle_type       head_i,
   output logic             pop_o,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [GestW-1:0] gesture_o,
   output logic [TimeW-1:0] duration_o,
   output logic             rsp_tlast
);

   logic             valid_ff;
   logic             second_ff;
   logic [GestW-1:0] gesture_ff;
   logic [TimeW-1:0] duration_ff;
   logic             last_ff;
   logic             load;

   assign load  = (~valid_ff | rsp_tready) & valid_i;
   assign pop_o = load & (second_ff | ~head_i.two);

   assign rsp_tvalid = valid_ff;
   assign gesture_o  = gesture_ff;
   assign duration_o = duration_ff;
   assign rsp_tlast  = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         if (load) begin
            valid_ff  <= 1'b1;
            second_ff <= ~pop_o;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (second_ff) begin
            gesture_ff  <= G_RESET;
            duration_ff <= '0;
            last_ff     <= 1'b1;
         end else begin
            gesture_ff  <= head_i.gesture;
            duration_ff <= head_i.duration;
            last_ff     <= ~head_i.two;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_second_is_reset: assert property (@(posedge clock) disable iff (reset)
      (load && second_ff) |=> gesture_ff == G_RESET && last_ff)
      else $error("second word is not a reset");
   a_second_has_bundle: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> valid_i) else $error("second word without its bundle");
   a_first_of_pair: assert property (@(posedge clock) disable iff (reset)
      (load && !second_ff && head_i.two) |=> second_ff && !last_ff)
      else $error("pair split wrongly");
`endif

endmodule

// ===== hw/rtl/button_click_hold_gesture_fsm_top.sv =====
// path: the first result word of a tick is written into the 2-entry queue and then
// loaded into the output register once that is free, from which it is offered on rsp
// throughput: one tick per cycle while the queue is not full; one result word per cycle
// while rsp_tready is high, set by the single output register draining the 2-entry queue
// reset: synchronous active high; registers return to their defaults, the gesture
// machine goes idle with all timers and the click count cleared, the queue empties
module button_click_hold_gesture_fsm_top import bcg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [15:0]       req_tdata,   // pressed, elapsed_ms[9:0], zero fill
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata,   // gesture[3:0], duration_ms[15:0], zero fill
   output logic              rsp_tlast,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [IndexW-1:0] csr_index,
   input  logic [TimeW-1:0]  csr_data
);

   logic             accept;
   logic             push, pop, full, q_valid;
   bundle_type       bundle, head;
   logic [GestW-1:0] gesture;
   logic [TimeW-1:0] duration;

   assign req_tready = ~full;
   assign accept     = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tdata  = {4'b0, duration, gesture};

   bcg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept_i  (accept),
      .pressed_i (req_tdata[0]),
      .elapsed_i (req_tdata[DtW:1]),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .push_o    (push),
      .bundle_o  (bundle)
   );

   bcg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_i   (push),
      .bundle_i (bundle),
      .pop_i    (pop),
      .full_o   (full),
      .valid_o  (q_valid),
      .head_o   (head)
   );

   bcg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .valid_i    (q_valid),
      .head_i     (head),
      .pop_o      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .gesture_o  (gesture),
      .duration_o (duration),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== sim/tb.sv =====
module tb;
   import bcg_pkg::*;

   typedef enum logic [2:0] {
      MODE_IDLE, MODE_PRESS, MODE_HOLD, MODE_OTA, MODE_GAP, MODE_SWALLOW
   } gesture_mode_type;

   typedef struct packed {
      logic [GestW-1:0] gesture;
      logic [TimeW-1:0] duration;
      logic             last;
   } gesture_word_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [15:0]       req_tdata;    // pressed, elapsed_ms[9:0], zero fill
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [23:0]       rsp_tdata;    // gesture[3:0], duration_ms[15:0], zero fill
   logic              rsp_tlast;
   logic              csr_valid;
   logic              csr_ready;
   logic [IndexW-1:0] csr_index;
   logic [TimeW-1:0]  csr_data;

   // shadow of the gesture machine and its registers
   gesture_mode_type  mode;
   logic              lvl_prev;
   logic [CountW-1:0] clicks;
   logic [TimeW-1:0]  press_ms;
   logic [TimeW-1:0]  gap_ms;
   logic [TimeW-1:0]  hold_thr;
   logic [TimeW-1:0]  click_win;
   logic [CountW-1:0] reset_clk;
   logic [CountW-1:0] ota_clk;
   logic [TimeW-1:0]  ota_hold;
   logic [TimeW-1:0]  stuck_lim;

   gesture_word_type gestures_due[$];
   int            fail_count = 0;
   int            ticks_sent = 0;
   bit            tx_idle = 1'b1;
   bit            rx_idle = 1'b1;
   int            rx_hold = 0;

   button_click_hold_gesture_fsm_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [TimeW-1:0] add_ms(input logic [TimeW-1:0] a,
                                               input logic [DtW-1:0] b);
      logic [TimeW:0] s;
      s = a + b;
      return s[TimeW] ? TimeMax : s[TimeW-1:0];
   endfunction

   function automatic void clear_sequence();
      mode     = MODE_IDLE;
      clicks   = '0;
      press_ms = '0;
      gap_ms   = '0;
   endfunction

   function automatic void predict_gestures(input logic lvl, input logic [DtW-1:0] dt);
      logic             rise;
      logic             fall;
      logic [GestW-1:0] gest [2];
      logic [TimeW-1:0] dur [2];
      int               n;
      gesture_word_type w;
      rise = lvl & ~lvl_prev;
      fall = ~lvl & lvl_prev;
      lvl_prev = lvl;
      n = 0;
      case (mode)
         MODE_PRESS: begin
            press_ms = add_ms(press_ms, dt);
            if (fall) begin
               if (clicks != CountMax) clicks = clicks + 4'd1;
               gest[n] = G_TICK;
               dur[n] = '0;
               n++;
               if (clicks >= reset_clk) begin
                  gest[n] = G_RESET;
                  dur[n] = '0;
                  n++;
                  clear_sequence();
               end else begin
                  mode = MODE_GAP;
                  gap_ms = '0;
               end
            end else if (press_ms >= hold_thr) begin
               if (clicks < MaxMulti) begin
                  gest[n] = G_HOLD1 + {clicks[2:0], 1'b0};
                  dur[n] = '0;
                  n++;
                  mode = MODE_HOLD;
               end else if (clicks == ota_clk) begin
                  mode = MODE_OTA;
               end else begin
                  mode = MODE_SWALLOW;
               end
            end
         end
         MODE_HOLD: begin
            press_ms = add_ms(press_ms, dt);
            if (fall) begin
               if (clicks < MaxMulti) begin
                  gest[n] = G_HOLD1 + {clicks[2:0], 1'b0} + 4'd1;
                  dur[n] = press_ms;
                  n++;
               end
               clear_sequence();
            end else if (press_ms >= stuck_lim) begin
               gest[n] = G_STUCK;
               dur[n] = press_ms;
               n++;
               clear_sequence();
            end
         end
         MODE_OTA: begin
            press_ms = add_ms(press_ms, dt);
            if (fall) begin
               clear_sequence();
            end else if (press_ms >= ota_hold) begin
               gest[n] = G_OTA;
               dur[n] = press_ms;
               n++;
               mode = MODE_SWALLOW;
            end
         end
         MODE_GAP: begin
            gap_ms = add_ms(gap_ms, dt);
            if (rise) begin
               mode = MODE_PRESS;
               press_ms = '0;
            end else if (gap_ms >= click_win) begin
               if (clicks >= 4'd1 && clicks <= MaxMulti) begin
                  gest[n] = G_CLICK1 + clicks - 4'd1;
                  dur[n] = '0;
                  n++;
               end
               clear_sequence();
            end
         end
         MODE_SWALLOW: begin
            if (fall) clear_sequence();
         end
         default: begin
            mode = MODE_IDLE;
            if (rise) begin
               mode = MODE_PRESS;
               press_ms = '0;
            end
         end
      endcase
      for (int i = 0; i < n; i++) begin
         w.gesture  = gest[i];
         w.duration = dur[i];
         w.last     = (i == n - 1);
         gestures_due.push_back(w);
      end
   endfunction

   task automatic send_tick(input logic lvl, input logic [DtW-1:0] dt);
      int pause;
      pause = tx_idle ? $urandom_range(0, 7) : 0;
      if (pause > 0) begin
         req_tvalid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, dt, lvl};
      do @(posedge clock); while (req_tready !== 1'b1);
      predict_gestures(lvl, dt);
      ticks_sent++;
   endtask

   task automatic send_level(input logic lvl, input int count, input int dt_max);
      logic [DtW-1:0] dt;
      for (int i = 0; i < count; i++) begin
         dt = DtW'($urandom_range(0, dt_max));
         send_tick(lvl, dt);
      end
   endtask

   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (gestures_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic configure(input logic [TimeW-1:0] h, input logic [TimeW-1:0] w,
                            input logic [CountW-1:0] r, input logic [CountW-1:0] o,
                            input logic [TimeW-1:0] oh, input logic [TimeW-1:0] s);
      logic [IndexW-1:0] idx [6];
      logic [TimeW-1:0]  val [6];
      idx = '{CSR_HOLD_THRESHOLD, CSR_CLICK_WINDOW, CSR_RESET_CLICKS,
              CSR_OTA_CLICKS, CSR_OTA_HOLD, CSR_STUCK};
      val = '{h, w, {12'b0, r}, {12'b0, o}, oh, s};
      quiesce();
      for (int i = 0; i < 6; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         do @(posedge clock); while (csr_ready !== 1'b1);
      end
      csr_valid <= 1'b0;
      hold_thr  = h;
      click_win = w;
      reset_clk = r;
      ota_clk   = o;
      ota_hold  = oh;
      stuck_lim = s;
   endtask

   function automatic logic [TimeW-1:0] pick_ms();
      case ($urandom_range(0, 11))
         0: return '0;
         1: return TimeMax;
         2, 3: return TimeW'($urandom_range(1, 64));
         default: return TimeW'($urandom_range(100, 4000));
      endcase
   endfunction

   task automatic test_default_gestures();
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      send_tick(1'b1, 10'd100);
      send_tick(1'b0, 10'd100);
      send_tick(1'b1, 10'd100);
      send_tick(1'b0, 10'd100);
      send_tick(1'b0, 10'd1023);
      send_tick(1'b1, 10'd0);
      send_tick(1'b1, 10'd600);
      send_tick(1'b0, 10'd10);
   endtask

   task automatic test_triple_and_stuck();
      configure(16'd50, 16'd50, 4'd15, 4'd3, 16'd200, 16'd300);
      send_tick(1'b1, 10'd0);
      send_tick(1'b0, 10'd1023);
      repeat (2) begin
         send_tick(1'b1, 10'd0);
         send_tick(1'b0, 10'd0);
      end
      send_tick(1'b0, 10'd1023);
      // stuck, then the late release is ignored
      send_tick(1'b1, 10'd0);
      send_tick(1'b1, 10'd1023);
      send_tick(1'b1, 10'd1023);
      send_tick(1'b0, 10'd5);
   endtask

   task automatic test_ota_gesture();
      repeat (3) begin
         send_tick(1'b1, 10'd0);
         send_tick(1'b0, 10'd0);
      end
      send_tick(1'b1, 10'd0);
      send_tick(1'b1, 10'd60);
      send_tick(1'b1, 10'd200);
      send_tick(1'b0, 10'd0);
   endtask

   task automatic test_zero_thresholds();
      configure('0, '0, '0, '0, '0, '0);
      send_tick(1'b1, 10'd0);
      send_tick(1'b0, 10'd0);
      send_tick(1'b1, 10'd3);
      send_tick(1'b1, 10'd0);
      send_tick(1'b1, 10'd0);
      send_tick(1'b0, 10'd0);
   endtask

   task automatic test_timer_saturation();
      configure(TimeMax, TimeMax, 4'd15, 4'd15, TimeMax, TimeMax);
      tx_idle = 1'b0;
      send_tick(1'b1, 10'd0);
      repeat (66) send_tick(1'b1, 10'd1023);
      send_tick(1'b0, 10'd0);
      send_tick(1'b1, 10'd0);
      send_tick(1'b0, 10'd1023);
      repeat (65) send_tick(1'b0, 10'd1023);
   endtask

   task automatic test_output_backpressure();
      configure(TimeMax, TimeMax, 4'd1, 4'd0, TimeMax, TimeMax);
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      rx_hold = 100;
      repeat (20) begin
         send_tick(1'b1, DtW'($urandom_range(0, 1023)));
         send_tick(1'b0, DtW'($urandom_range(0, 1023)));
      end
   endtask

   task automatic send_random_sequence();
      int presses;
      int click_dt;
      int gap_dt;
      click_dt = int'(hold_thr) / 4;
      gap_dt   = int'(click_win) / 4;
      if (click_dt > 1023) click_dt = 1023;
      if (gap_dt > 1023) gap_dt = 1023;
      case ($urandom_range(0, 7))
         0, 1, 2: presses = $urandom_range(0, 3);
         3: presses = int'(ota_clk);
         4: presses = int'(reset_clk);
         5: presses = $urandom_range(4, 17);
         default: presses = $urandom_range(1, 2);
      endcase
      for (int i = 0; i < presses; i++) begin
         send_level(1'b1, $urandom_range(1, 2), click_dt);
         send_level(1'b0, $urandom_range(1, 2), gap_dt);
      end
      case ($urandom_range(0, 4))
         0, 1: send_level(1'b1, $urandom_range(2, 14), 1023);
         2: send_level(1'b1, $urandom_range(1, 3), click_dt);
         default: begin
            repeat ($urandom_range(1, 8))
               send_tick(1'($urandom_range(0, 1)), DtW'($urandom_range(0, 1023)));
         end
      endcase
      send_level(1'b0, $urandom_range(1, 6), 1023);
   endtask

   task automatic test_random_gestures();
      int goal;
      for (int p = 0; p < 8; p++) begin
         configure(pick_ms(), pick_ms(),
                   CountW'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                        : $urandom_range(3, 8)),
                   CountW'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 15)
                                                        : $urandom_range(3, 5)),
                   pick_ms(), pick_ms());
         tx_idle = ($urandom_range(0, 3) != 0);
         rx_idle = ($urandom_range(0, 3) != 0);
         goal = ticks_sent + 50;
         while (ticks_sent < goal) send_random_sequence();
      end
   endtask

   initial begin : rsp_sink
      int pause;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         pause = rx_idle ? $urandom_range(0, 7) : 0;
         if (rx_hold > 0) begin
            pause = rx_hold;
            rx_hold = 0;
         end
         if (pause > 0) begin
            rsp_tready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
      end
   end

   always @(posedge clock) begin : check_words
      gesture_word_type want;
      if (reset === 1'b0 && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (gestures_due.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual gesture %0d duration %0d",
                     $time, rsp_tdata[3:0], rsp_tdata[19:4]);
            fail_count++;
         end else begin
            want = gestures_due.pop_front();
            if (rsp_tdata[3:0] !== want.gesture) begin
               $display("%0t: gesture expected %0d actual %0d",
                        $time, want.gesture, rsp_tdata[3:0]);
               fail_count++;
            end
            if (rsp_tdata[19:4] !== want.duration) begin
               $display("%0t: duration expected %0d actual %0d",
                        $time, want.duration, rsp_tdata[19:4]);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last expected %0b actual %0b", $time, want.last, rsp_tlast);
               fail_count++;
            end
            if (rsp_tdata[23:20] !== 4'd0) begin
               $display("%0t: fill bits expected 0 actual %0h", $time, rsp_tdata[23:20]);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #4000000;
      $display("status: fail");
      $finish;
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      hold_thr   = 16'd500;
      click_win  = 16'd400;
      reset_clk  = 4'd10;
      ota_clk    = 4'd4;
      ota_hold   = 16'd10000;
      stuck_lim  = 16'd30000;
      lvl_prev   = 1'b0;
      clear_sequence();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_default_gestures();
      test_triple_and_stuck();
      test_ota_gesture();
      test_zero_thresholds();
      test_timer_saturation();
      test_output_backpressure();
      test_random_gestures();
      quiesce();
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/bcg_pkg.sv
hw/rtl/bcg_front.sv
hw/rtl/bcg_queue.sv
hw/rtl/bcg_back.sv
hw/rtl/button_click_hold_gesture_fsm_top.sv
sim/tb.sv
